// ----- rtl/fxa_pkg.sv -----
// ----------------------------------------------------------------------------
// fxa_pkg
// opcodes, status codes and shared types of the q24.8 fixed-point alu
// ----------------------------------------------------------------------------
package fxa_pkg;

    typedef logic [3:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_ADD  = 4'd0;
    localparam t_op OP_SUB  = 4'd1;
    localparam t_op OP_MUL  = 4'd2;
    localparam t_op OP_DIV  = 4'd3;
    localparam t_op OP_GT   = 4'd4;
    localparam t_op OP_LT   = 4'd5;
    localparam t_op OP_GE   = 4'd6;
    localparam t_op OP_LE   = 4'd7;
    localparam t_op OP_EQ   = 4'd8;
    localparam t_op OP_NE   = 4'd9;
    localparam t_op OP_INC  = 4'd10;
    localparam t_op OP_DEC  = 4'd11;
    localparam t_op OP_MIN  = 4'd12;
    localparam t_op OP_MAX  = 4'd13;
    localparam t_op OP_FINT = 4'd14;
    localparam t_op OP_TINT = 4'd15;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_OVF  = 2'd1;
    localparam t_status ST_DIV0 = 2'd2;

endpackage

// ----- rtl/fixed_point_q24_8_alu.sv -----
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// signed q24.8 fixed-point alu with saturation and rounded mul/div
// ----------------------------------------------------------------------------
// A new word is taken in every cycle (busy is always low) and its result
// appears on the o_ ports with o_valid high for one cycle, after the same
// registers for every opcode: input, stage 2, stage 3, the bit-per-stage
// divider pipeline that all words flow through in step so results leave in
// order, and output register. The receiver cannot stall and none is needed.
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  fxa_pkg::t_op          i_req_type,
    input  logic signed [31:0]    i_operand_a,
    input  logic signed [31:0]    i_operand_b,
    output logic                  o_valid,
    output logic signed [31:0]    o_result_value,
    output logic                  o_compare_true,
    output fxa_pkg::t_status      o_status
);
    import fxa_pkg::*;

    localparam int NW = 32 + 2 * FRAC_BITS + 1; // 2*|a|<<F + |b|
    localparam int DW = 33;                     // 2*|b|
    localparam int TW = 4 + 32 + 1 + 2 + 1;

    assign busy = 1'b0;

    // stage 1: register inputs
    logic        r_v1;
    t_op         r_op1;
    logic signed [31:0] r_a1, r_b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_op1 <= i_req_type;
        r_a1  <= i_operand_a;
        r_b1  <= i_operand_b;
    end

    // stage 2: magnitudes, simple ops, multiplier
    logic [31:0] n_ma, n_mb;
    logic        n_neg;
    logic signed [33:0] n_sum;
    logic signed [31:0] n_res;
    logic        n_cmp;
    t_status     n_st;
    always_comb begin
        logic signed [32:0] ext;
        logic signed [32+FRAC_BITS:0] sh;
        n_ma  = r_a1[31] ? 32'(-r_a1) : 32'(r_a1);
        n_mb  = r_b1[31] ? 32'(-r_b1) : 32'(r_b1);
        n_neg = r_a1[31] ^ r_b1[31];
        n_res = '0;
        n_cmp = 1'b0;
        n_st  = ST_OK;
        n_sum = '0;
        ext   = '0;
        sh    = '0;
        unique case (r_op1)
            OP_ADD: n_sum = 34'(r_a1) + 34'(r_b1);
            OP_SUB: n_sum = 34'(r_a1) - 34'(r_b1);
            OP_INC: n_sum = 34'(r_a1) + 34'sd1;
            OP_DEC: n_sum = 34'(r_a1) - 34'sd1;
            default: n_sum = '0;
        endcase
        unique case (r_op1)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                if (n_sum > 34'sh7FFFFFFF) begin
                    n_res = 32'sh7FFFFFFF; n_st = ST_OVF;
                end else if (n_sum < -34'sh80000000) begin
                    n_res = 32'sh80000000; n_st = ST_OVF;
                end else begin
                    n_res = n_sum[31:0];
                end
            end
            OP_GT: n_cmp = r_a1 >  r_b1;
            OP_LT: n_cmp = r_a1 <  r_b1;
            OP_GE: n_cmp = r_a1 >= r_b1;
            OP_LE: n_cmp = r_a1 <= r_b1;
            OP_EQ: n_cmp = r_a1 == r_b1;
            OP_NE: n_cmp = r_a1 != r_b1;
            OP_MIN: n_res = (r_a1 < r_b1) ? r_a1 : r_b1;
            OP_MAX: n_res = (r_a1 > r_b1) ? r_a1 : r_b1;
            OP_FINT: begin
                sh = (33+FRAC_BITS)'(r_a1) <<< FRAC_BITS;
                if (sh > (33+FRAC_BITS)'(32'sh7FFFFFFF)) begin
                    n_res = 32'sh7FFFFFFF; n_st = ST_OVF;
                end else if (sh < -(33+FRAC_BITS)'(33'sh080000000)) begin
                    n_res = 32'sh80000000; n_st = ST_OVF;
                end else begin
                    n_res = sh[31:0];
                end
            end
            OP_TINT: begin
                ext = 33'(r_a1) >>> FRAC_BITS;
                n_res = ext[31:0];
            end
            OP_DIV: n_st = (r_b1 == 0) ? ST_DIV0 : ST_OK;
            default: ;
        endcase
    end

    logic        r_v2, r_neg2;
    t_op         r_op2;
    logic [63:0] r_prod2;
    logic [31:0] r_ma2, r_mb2;
    logic signed [31:0] r_res2;
    logic        r_cmp2;
    t_status     r_st2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_op2   <= r_op1;
        r_prod2 <= 64'(n_ma) * 64'(n_mb);
        r_ma2   <= n_ma;
        r_mb2   <= n_mb;
        r_neg2  <= n_neg;
        r_res2  <= n_res;
        r_cmp2  <= n_cmp;
        r_st2   <= n_st;
    end

    // stage 3: mul rounding and saturation, divider operand prep
    logic [64-FRAC_BITS:0] n_mm;
    logic signed [31:0] n_res3;
    t_status n_st3;
    always_comb begin
        n_mm   = (65-FRAC_BITS)'((65'(r_prod2) + 65'(1) * (65'(1) << (FRAC_BITS-1)))
                  >> FRAC_BITS);
        n_res3 = r_res2;
        n_st3  = r_st2;
        if (r_op2 == OP_MUL) begin
            if (r_neg2) begin
                if (n_mm > (65-FRAC_BITS)'(33'h080000000)) begin
                    n_res3 = 32'sh80000000; n_st3 = ST_OVF;
                end else begin
                    n_res3 = 32'(-n_mm);
                end
            end else if (n_mm > (65-FRAC_BITS)'(32'h7FFFFFFF)) begin
                n_res3 = 32'sh7FFFFFFF; n_st3 = ST_OVF;
            end else begin
                n_res3 = n_mm[31:0];
            end
        end
    end

    logic        r_v3;
    logic [NW-1:0] r_num3;
    logic [DW-1:0] r_den3;
    logic [TW-1:0] r_tag3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_num3 <= NW'(({(NW-32)'(0), r_ma2} << (FRAC_BITS + 1)) + NW'(r_mb2));
        r_den3 <= {r_mb2, 1'b0};
        r_tag3 <= {r_op2, n_res3, r_cmp2, n_st3, r_neg2};
    end

    // divider pipeline, all words pass through it to keep order
    logic          w_dv;
    logic [NW-1:0] w_q;
    logic [TW-1:0] w_tag;
    fxa_div #(.NW(NW), .DW(DW), .TW(TW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v3),
        .i_num(r_num3), .i_den(r_den3), .i_tag(r_tag3),
        .o_valid(w_dv), .o_quot(w_q), .o_tag(w_tag)
    );

    // final: div sign and saturation, output register
    t_op  w_op;
    logic signed [31:0] w_res;
    logic w_cmp, w_neg;
    t_status w_st;
    assign {w_op, w_res, w_cmp, w_st, w_neg} = w_tag;

    logic signed [31:0] n_out;
    t_status n_sto;
    always_comb begin
        n_out = w_res;
        n_sto = w_st;
        if (w_op == OP_DIV && w_st != ST_DIV0) begin
            if (w_neg) begin
                if (w_q > NW'(33'h080000000)) begin
                    n_out = 32'sh80000000; n_sto = ST_OVF;
                end else begin
                    n_out = 32'(-w_q);
                end
            end else if (w_q > NW'(32'h7FFFFFFF)) begin
                n_out = 32'sh7FFFFFFF; n_sto = ST_OVF;
            end else begin
                n_out = w_q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_dv;
        end
        o_result_value <= n_out;
        o_compare_true <= w_cmp;
        o_status       <= n_sto;
    end

`ifndef SYNTHESIS
    // compare flag only with a zero result
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> o_result_value == 0 && o_status == ST_OK)
        else $error("compare word with nonzero result");
    // divide by zero gives zero
    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DIV0 |-> o_result_value == 0)
        else $error("divide by zero result not zero");
    // stage valids follow input
    a_v2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |=> r_v2)
        else $error("word lost in stage two");
`endif
endmodule

// ----- rtl/fxa_div.sv -----
// ----------------------------------------------------------------------------
// fxa_div
// pipelined restoring divider, one quotient bit per stage, with tag passthru
// ----------------------------------------------------------------------------
module fxa_div #(
    parameter int NW = 41,
    parameter int DW = 33,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quot,
    output logic [TW-1:0] o_tag
);
    // stage s holds partial remainder, shifted numerator bits and quotient
    logic [NW:1]     r_vld;
    logic [DW-1:0]   r_rem  [1:NW];
    logic [NW-1:0]   r_num  [1:NW];
    logic [NW-1:0]   r_quo  [1:NW];
    logic [DW-1:0]   r_den  [1:NW];
    logic [TW-1:0]   r_tag  [1:NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic          w_vld_in;
        logic [DW-1:0] w_rem_in;
        logic [NW-1:0] w_num_in;
        logic [NW-1:0] w_quo_in;
        logic [DW-1:0] w_den_in;
        logic [TW-1:0] w_tag_in;
        logic [DW:0]   n_trial;
        logic [DW:0]   n_rem;

        // first stage takes the new word, later stages the previous stage
        if (s == 0) begin : g_first
            assign w_vld_in = i_valid;
            assign w_rem_in = '0;
            assign w_num_in = i_num;
            assign w_quo_in = '0;
            assign w_den_in = i_den;
            assign w_tag_in = i_tag;
        end else begin : g_next
            assign w_vld_in = r_vld[s];
            assign w_rem_in = r_rem[s];
            assign w_num_in = r_num[s];
            assign w_quo_in = r_quo[s];
            assign w_den_in = r_den[s];
            assign w_tag_in = r_tag[s];
        end

        // shift in next numerator bit and try a subtract
        always_comb begin
            n_trial = {w_rem_in, w_num_in[NW-1]};
            n_rem   = n_trial - {1'b0, w_den_in};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= w_vld_in;
            end
            r_den[s+1] <= w_den_in;
            r_tag[s+1] <= w_tag_in;
            r_num[s+1] <= {w_num_in[NW-2:0], 1'b0};
            if (!n_rem[DW]) begin
                r_rem[s+1] <= n_rem[DW-1:0];
                r_quo[s+1] <= {w_quo_in[NW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_trial[DW-1:0];
                r_quo[s+1] <= {w_quo_in[NW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quot  = r_quo[NW];
    assign o_tag   = r_tag[NW];
endmodule

// ----- sim/fixed_point_q24_8_alu_tb.sv -----
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb
// self-checking bench for the signed q24.8 alu: directed corner words, then
// random words under three idling mixes, each result compared to a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_tb;

    import fxa_pkg::*;

    localparam int FRAC    = 8;
    localparam int LATENCY = 3 + 32 + 2 * FRAC + 1;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] value;
        logic               cmp;
        t_status            status;
    } t_alu_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_op                i_req_type = OP_ADD;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_valid;
    logic signed [31:0] o_result_value;
    logic               o_compare_true;
    t_status            o_status;

    t_alu_result pending_results[$];
    int          error_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          idle_pct = 0;

    fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b), .o_valid(o_valid),
        .o_result_value(o_result_value), .o_compare_true(o_compare_true),
        .o_status(o_status)
    );

    always #2 i_clk = ~i_clk;

    // signed value from sign and magnitude, saturated to 32 bits
    function automatic t_alu_result saturate_mag(bit neg, logic [63:0] m);
        t_alu_result r;
        r = '0;
        if (neg) begin
            if (m > 64'h80000000) begin
                r.value = MINV; r.status = ST_OVF;
            end else begin
                r.value = 32'(-$signed(m));
            end
        end else if (m > 64'h7fffffff) begin
            r.value = MAXV; r.status = ST_OVF;
        end else begin
            r.value = m[31:0];
        end
        return r;
    endfunction

    function automatic t_alu_result clamp_wide(logic signed [63:0] v);
        t_alu_result r;
        r = '0;
        if (v > 64'sh7fffffff) begin
            r.value = MAXV; r.status = ST_OVF;
        end else if (v < -64'sh80000000) begin
            r.value = MINV; r.status = ST_OVF;
        end else begin
            r.value = v[31:0];
        end
        return r;
    endfunction

    // expected result of one alu word
    function automatic t_alu_result alu_result(t_op op, logic signed [31:0] a,
                                               logic signed [31:0] b);
        t_alu_result r;
        logic signed [63:0] wa, wb;
        logic [63:0] ma, mb, m, num;
        bit neg;
        r = '0;
        wa = a; wb = b;
        ma = wa < 0 ? -wa : wa;
        mb = wb < 0 ? -wb : wb;
        neg = (a < 0) != (b < 0);
        case (op)
            OP_ADD: r = clamp_wide(wa + wb);
            OP_SUB: r = clamp_wide(wa - wb);
            OP_MUL: begin
                m = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
                r = saturate_mag(neg, m);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.status = ST_DIV0;
                end else begin
                    num = ma << FRAC;
                    r = saturate_mag(neg, (2 * num + mb) / (2 * mb));
                end
            end
            OP_GT: r.cmp = a > b;
            OP_LT: r.cmp = a < b;
            OP_GE: r.cmp = a >= b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_INC: r = clamp_wide(wa + 1);
            OP_DEC: r = clamp_wide(wa - 1);
            OP_MIN: r.value = (a < b) ? a : b;
            OP_MAX: r.value = (a > b) ? a : b;
            OP_FINT: r = clamp_wide(wa * (64'sd1 <<< FRAC));
            default: r.value = a >>> FRAC;
        endcase
        return r;
    endfunction

    // send one word, idling first at the current rate
    task automatic send_word(t_op op, logic signed [31:0] a, logic signed [31:0] b);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(alu_result(op, a, b));
        words_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // operand biased toward corners and small values
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(9))
            0: return MAXV;
            1: return MINV;
            2: return 32'($signed($urandom_range(0, 2048)) - 1024);
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed;
        t_op op;
        send_word(OP_ADD, MAXV, 32'sd1);
        send_word(OP_ADD, MINV, -32'sd1);
        send_word(OP_SUB, MINV, 32'sd1);
        send_word(OP_SUB, MAXV, MINV);
        send_word(OP_MUL, 32'sd384, -32'sd384);
        send_word(OP_MUL, 32'sd1, 32'sd128);
        send_word(OP_MUL, -32'sd1, 32'sd128);
        send_word(OP_MUL, MINV, MINV);
        send_word(OP_DIV, 32'sd256, 32'sd0);
        send_word(OP_DIV, MINV, 32'sd1);
        send_word(OP_DIV, -32'sd1, 32'sd512);
        send_word(OP_DIV, MINV, -32'sd256);
        send_word(OP_INC, MAXV, 32'sd5);
        send_word(OP_DEC, MINV, -32'sd5);
        send_word(OP_MIN, 32'sd7, 32'sd7);
        send_word(OP_MAX, -32'sd3, -32'sd3);
        send_word(OP_FINT, 32'sh00800000, 32'sd0);
        send_word(OP_FINT, -32'sh00800000, 32'sd0);
        send_word(OP_TINT, -32'sd1, MAXV);
        send_word(OP_TINT, MINV, 32'sd0);
        for (int i = OP_GT; i <= OP_NE; i++) begin
            op = t_op'(i);
            send_word(op, MINV, MAXV);
            send_word(op, 32'sd9, 32'sd9);
        end
        drain();
    endtask

    task automatic test_random(int count, int pct);
        idle_pct = pct;
        repeat (count) send_word(t_op'($urandom_range(15)), pick_operand(), pick_operand());
        drain();
    endtask

    // check each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d cmp=%0b status=%0d",
                         $time, o_result_value, o_compare_true, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (o_result_value !== want.value) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.value, o_result_value);
                    error_count++;
                end
                if (o_compare_true !== want.cmp) begin
                    $display("%0t: compare expected %0b actual %0b",
                             $time, want.cmp, o_compare_true);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(210, 18);
        test_random(210, 46);
        test_random(210, 0);
        $display("covered %0d words over all opcodes, %0d results checked",
                 words_sent, words_checked);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/fxa_pkg.sv
rtl/fxa_div.sv
rtl/fixed_point_q24_8_alu.sv
sim/fixed_point_q24_8_alu_tb.sv
